>>> rtl/btkv_pkg.sv
package btkv_pkg;

  // Fixed widths of the channel fields.
  localparam int CMD_W   = 3;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int TOTAL_W = 11;

  // Defaults for the top-level parameters.
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_NODE_COUNT = 1024;
  localparam int DEF_VALUE_BITS = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_ANY    = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_COUNT  = 3'd5
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_IC_STEP,
    ST_IC_WAIT,
    ST_IC_CHECK,
    ST_ALLOC,
    ST_ALLOC_WAIT,
    ST_ALLOC_FIN,
    ST_ALLOC_LINK,
    ST_IB_STEP,
    ST_IB_WAIT,
    ST_IB_FINAL,
    ST_F_STEP,
    ST_F_WAIT,
    ST_F_FINAL,
    ST_D_STEP,
    ST_D_WAIT,
    ST_D_FINAL,
    ST_P_CHECK,
    ST_P_PATH,
    ST_P_NODE,
    ST_A_STEP,
    ST_A_WAIT,
    ST_DONE
  } state_t;

endpackage

>>> rtl/btkv_cmd_if.sv
interface btkv_cmd_if
  import btkv_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

>>> rtl/btkv_rsp_if.sv
interface btkv_rsp_if
  import btkv_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               found;
  logic [VALUE_W-1:0] value_out;
  logic [TOTAL_W-1:0] entry_total;
  logic               status;

  modport source (output valid, output found, output value_out, output entry_total,
                  output status, input ready);
  modport sink   (input valid, input found, input value_out, input entry_total,
                  input status, output ready);
endinterface

>>> rtl/binary_trie_key_value_map.sv
// Key-to-value map kept as a binary trie in a pool of NODE_COUNT nodes held in a
// synchronous node memory, with a second memory as the stack of freed nodes and a
// small one holding the path of a delete for pruning. One command is worked at a
// time; every command gives exactly one result transfer. Each trie step is a node
// read, then a decode, since the node memory has a registered read port. An insert
// first counts the nodes it needs, then walks again and allocates the missing
// ones; a delete walks down the key and then prunes the nodes it frees. Clear and
// count go straight to the result. The next command is taken while a result still
// waits to be read out.
// No clearing pass is needed after reset: only nodes written at allocation are read.
module binary_trie_key_value_map
  import btkv_pkg::*;
#(
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int NODE_COUNT = DEF_NODE_COUNT,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  btkv_cmd_if.sink   in_ch,
  btkv_rsp_if.source out_ch
);

  // Effective key and value widths; the ports carry at most 32 bits each.
  localparam int KW  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int VW  = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int AW  = $clog2(NODE_COUNT);
  localparam int LW  = AW + 1;
  localparam int CW  = $clog2(NODE_COUNT + 1);
  localparam int NW  = $clog2(KW + 2);
  localparam int SW  = $clog2(KW + 2);
  localparam int PD  = KW + 1;
  localparam int PIW = (KW > 1) ? $clog2(KW + 1) : 1;
  localparam int FW  = ((CW > NW) ? CW : NW) + 1;

  localparam logic [LW-1:0] NONE     = LW'(NODE_COUNT);
  localparam logic [SW-1:0] PATH_LEN = SW'(KW + 1);

  typedef struct packed {
    logic [LW-1:0] link0;
    logic [LW-1:0] link1;
    logic          holds;
    logic [VW-1:0] data;
  } node_t;

  typedef struct packed {
    logic [AW-1:0] node;
    logic          dir;
  } path_ent_t;

  // Memories.
  node_t         node_mem [NODE_COUNT];
  logic [AW-1:0] fs_mem   [NODE_COUNT];
  path_ent_t     path_mem [PD];

  node_t         node_rd_r;
  logic [AW-1:0] fs_rd_r;
  path_ent_t     path_rd_r;

  logic          node_we;
  logic [AW-1:0] node_waddr;
  node_t         node_wdata;
  logic [AW-1:0] node_raddr;
  logic          fs_we;
  logic [AW-1:0] fs_waddr;
  logic [AW-1:0] fs_wdata;
  logic [AW-1:0] fs_raddr;
  logic          path_we;
  logic [PIW-1:0] path_waddr;
  path_ent_t     path_wdata;
  logic [PIW-1:0] path_raddr;

  // Control and working registers.
  state_t         state_r, state_nxt;
  logic [KW-1:0]  key_r, key_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [VW-1:0]  val_r, val_nxt;
  logic [LW-1:0]  cur_r, cur_nxt;
  logic [NW-1:0]  need_r, need_nxt;
  logic [SW-1:0]  steps_r, steps_nxt;
  logic [PIW-1:0] len_r, len_nxt;
  logic           dir_r, dir_nxt;
  logic           to_root_r, to_root_nxt;
  logic [AW-1:0]  new_r, new_nxt;
  node_t          node_r, node_nxt;
  logic [CW-1:0]  free_top_r, free_top_nxt;
  logic [CW-1:0]  next_unused_r, next_unused_nxt;
  logic [LW-1:0]  root_r, root_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           res_found_r, res_found_nxt;
  logic [VW-1:0]  res_value_r, res_value_nxt;
  logic           res_status_r, res_status_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_found_r, out_found_nxt;
  logic [VW-1:0]  out_value_r, out_value_nxt;
  logic [CW-1:0]  out_total_r, out_total_nxt;
  logic           out_status_r, out_status_nxt;

  // Shared conditions.
  logic          accept;
  logic          cur_node;
  logic          root_node;
  logic          k_zero;
  logic [LW-1:0] rd_child;
  logic          child_node;
  logic          zero_node;
  logic [FW-1:0] free_avail;
  logic          need_ok;
  logic          keep_node;
  logic          out_free;
  logic          fs_nonempty;

  assign accept      = in_ch.valid && in_ch.ready;
  assign cur_node    = cur_r < NONE;
  assign root_node   = root_r < NONE;
  assign k_zero      = (k_r == '0);
  assign rd_child    = k_r[0] ? node_rd_r.link1 : node_rd_r.link0;
  assign child_node  = rd_child < NONE;
  assign zero_node   = node_rd_r.link0 < NONE;
  assign free_avail  = FW'(free_top_r) + FW'(NODE_COUNT) - FW'(next_unused_r);
  assign need_ok     = FW'(need_r) <= free_avail;
  assign keep_node   = node_r.holds || (node_r.link0 < NONE) || (node_r.link1 < NONE);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign fs_nonempty = (free_top_r != '0);

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.value_out   = VALUE_W'(out_value_r);
  assign out_ch.entry_total = TOTAL_W'(out_total_r);
  assign out_ch.status      = out_status_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.cmd)
            CMD_INSERT: state_nxt = ST_IC_STEP;
            CMD_LOOKUP: state_nxt = ST_F_STEP;
            CMD_DELETE: state_nxt = ST_D_STEP;
            CMD_ANY:    state_nxt = ST_A_STEP;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_IC_STEP: begin
        if (k_zero) state_nxt = ST_IC_CHECK;
        else if (cur_node) state_nxt = ST_IC_WAIT;
      end
      ST_IC_WAIT:  state_nxt = ST_IC_STEP;
      ST_IC_CHECK: begin
        if (!need_ok) state_nxt = ST_DONE;
        else if (root_node) state_nxt = ST_IB_STEP;
        else state_nxt = ST_ALLOC;
      end
      ST_ALLOC:      state_nxt = fs_nonempty ? ST_ALLOC_WAIT : ST_ALLOC_FIN;
      ST_ALLOC_WAIT: state_nxt = ST_ALLOC_FIN;
      ST_ALLOC_FIN:  state_nxt = to_root_r ? ST_IB_STEP : ST_ALLOC_LINK;
      ST_ALLOC_LINK: state_nxt = ST_IB_STEP;
      ST_IB_STEP:    state_nxt = k_zero ? ST_IB_FINAL : ST_IB_WAIT;
      ST_IB_WAIT:    state_nxt = child_node ? ST_IB_STEP : ST_ALLOC;
      ST_IB_FINAL:   state_nxt = ST_DONE;
      ST_F_STEP: begin
        if (!cur_node) state_nxt = ST_DONE;
        else state_nxt = k_zero ? ST_F_FINAL : ST_F_WAIT;
      end
      ST_F_WAIT:  state_nxt = ST_F_STEP;
      ST_F_FINAL: state_nxt = ST_DONE;
      ST_D_STEP: begin
        if (!cur_node) state_nxt = ST_DONE;
        else state_nxt = k_zero ? ST_D_FINAL : ST_D_WAIT;
      end
      ST_D_WAIT:  state_nxt = ST_D_STEP;
      ST_D_FINAL: state_nxt = node_rd_r.holds ? ST_P_CHECK : ST_DONE;
      ST_P_CHECK: begin
        if (keep_node || len_r == '0) state_nxt = ST_DONE;
        else state_nxt = ST_P_PATH;
      end
      ST_P_PATH: state_nxt = ST_P_NODE;
      ST_P_NODE: state_nxt = ST_P_CHECK;
      ST_A_STEP: state_nxt = cur_node ? ST_A_WAIT : ST_DONE;
      ST_A_WAIT: begin
        if (node_rd_r.holds || steps_r == PATH_LEN) state_nxt = ST_DONE;
        else state_nxt = ST_A_STEP;
      end
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory controls and result registers.
  always_comb begin
    key_nxt         = key_r;
    k_nxt           = k_r;
    val_nxt         = val_r;
    cur_nxt         = cur_r;
    need_nxt        = need_r;
    steps_nxt       = steps_r;
    len_nxt         = len_r;
    dir_nxt         = dir_r;
    to_root_nxt     = to_root_r;
    new_nxt         = new_r;
    node_nxt        = node_r;
    free_top_nxt    = free_top_r;
    next_unused_nxt = next_unused_r;
    root_nxt        = root_r;
    count_nxt       = count_r;
    res_found_nxt   = res_found_r;
    res_value_nxt   = res_value_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_found_nxt   = out_found_r;
    out_value_nxt   = out_value_r;
    out_total_nxt   = out_total_r;
    out_status_nxt  = out_status_r;

    node_we    = 1'b0;
    node_waddr = cur_r[AW-1:0];
    node_wdata = node_r;
    node_raddr = cur_r[AW-1:0];
    fs_we      = 1'b0;
    fs_waddr   = free_top_r[AW-1:0];
    fs_wdata   = cur_r[AW-1:0];
    fs_raddr   = AW'(free_top_r - CW'(1));
    path_we    = 1'b0;
    path_waddr = len_r;
    path_wdata = '{node: cur_r[AW-1:0], dir: k_r[0]};
    path_raddr = PIW'(len_r - PIW'(1));

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt        = in_ch.key[KW-1:0];
          k_nxt          = in_ch.key[KW-1:0];
          val_nxt        = in_ch.value[VW-1:0];
          cur_nxt        = root_r;
          need_nxt       = root_node ? '0 : NW'(1);
          steps_nxt      = '0;
          len_nxt        = '0;
          res_found_nxt  = 1'b0;
          res_value_nxt  = '0;
          res_status_nxt = 1'b0;
          if (in_ch.cmd == CMD_CLEAR) begin
            free_top_nxt    = '0;
            next_unused_nxt = '0;
            root_nxt        = NONE;
            count_nxt       = '0;
          end
        end
      end
      ST_IC_STEP: begin
        if (!k_zero && !cur_node) begin
          need_nxt = need_r + NW'(1);
          k_nxt    = k_r >> 1;
        end
      end
      ST_IC_WAIT: begin
        cur_nxt = rd_child;
        if (!child_node) need_nxt = need_r + NW'(1);
        k_nxt = k_r >> 1;
      end
      ST_IC_CHECK: begin
        k_nxt = key_r;
        if (!need_ok) begin
          res_status_nxt = 1'b1;
        end else if (root_node) begin
          cur_nxt = root_r;
        end else begin
          to_root_nxt = 1'b1;
        end
      end
      ST_ALLOC: begin
        if (fs_nonempty) begin
          free_top_nxt = free_top_r - CW'(1);
        end else begin
          new_nxt         = next_unused_r[AW-1:0];
          next_unused_nxt = next_unused_r + CW'(1);
        end
      end
      ST_ALLOC_WAIT: new_nxt = fs_rd_r;
      ST_ALLOC_FIN: begin
        node_we    = 1'b1;
        node_waddr = new_r;
        node_wdata = '{link0: NONE, link1: NONE, holds: 1'b0, data: '0};
        if (to_root_r) begin
          root_nxt = LW'(new_r);
          cur_nxt  = LW'(new_r);
        end
      end
      ST_ALLOC_LINK: begin
        node_we    = 1'b1;
        node_wdata = node_r;
        if (dir_r) node_wdata.link1 = LW'(new_r);
        else node_wdata.link0 = LW'(new_r);
        cur_nxt = LW'(new_r);
      end
      ST_IB_WAIT: begin
        node_nxt = node_rd_r;
        k_nxt    = k_r >> 1;
        if (child_node) begin
          cur_nxt = rd_child;
        end else begin
          dir_nxt     = k_r[0];
          to_root_nxt = 1'b0;
        end
      end
      ST_IB_FINAL: begin
        res_found_nxt    = node_rd_r.holds;
        node_we          = 1'b1;
        node_wdata       = node_rd_r;
        node_wdata.holds = 1'b1;
        node_wdata.data  = val_r;
        if (!node_rd_r.holds) count_nxt = count_r + CW'(1);
      end
      ST_F_WAIT: begin
        cur_nxt = rd_child;
        k_nxt   = k_r >> 1;
      end
      ST_F_FINAL: begin
        res_found_nxt = node_rd_r.holds;
        res_value_nxt = node_rd_r.holds ? node_rd_r.data : '0;
      end
      ST_D_STEP: begin
        if (cur_node) path_we = 1'b1;
      end
      ST_D_WAIT: begin
        cur_nxt = rd_child;
        k_nxt   = k_r >> 1;
        len_nxt = len_r + PIW'(1);
      end
      ST_D_FINAL: begin
        if (node_rd_r.holds) begin
          res_found_nxt  = 1'b1;
          if (count_r != '0) count_nxt = count_r - CW'(1);
          node_nxt       = node_rd_r;
          node_nxt.holds = 1'b0;
          node_nxt.data  = '0;
        end
      end
      ST_P_CHECK: begin
        if (keep_node) begin
          node_we = 1'b1;
        end else begin
          if (free_top_r < CW'(NODE_COUNT)) begin
            fs_we        = 1'b1;
            free_top_nxt = free_top_r + CW'(1);
          end
          if (len_r == '0) root_nxt = NONE;
          else len_nxt = len_r - PIW'(1);
        end
      end
      ST_P_PATH: begin
        cur_nxt    = LW'(path_rd_r.node);
        dir_nxt    = path_rd_r.dir;
        node_raddr = path_rd_r.node;
      end
      ST_P_NODE: begin
        node_nxt = node_rd_r;
        if (dir_r) node_nxt.link1 = NONE;
        else node_nxt.link0 = NONE;
      end
      ST_A_WAIT: begin
        if (node_rd_r.holds) begin
          res_found_nxt = 1'b1;
          res_value_nxt = node_rd_r.data;
        end else if (steps_r != PATH_LEN) begin
          cur_nxt   = zero_node ? node_rd_r.link0 : node_rd_r.link1;
          steps_nxt = steps_r + SW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_value_nxt  = res_value_r;
          out_total_nxt  = count_r;
          out_status_nxt = res_status_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Memories: one write port and one registered read port each.
  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rd_r <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fs_waddr] <= fs_wdata;
    fs_rd_r <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk) begin
    if (path_we) path_mem[path_waddr] <= path_wdata;
    path_rd_r <= path_mem[path_raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      free_top_r    <= '0;
      next_unused_r <= '0;
      root_r        <= NONE;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      free_top_r    <= free_top_nxt;
      next_unused_r <= next_unused_nxt;
      root_r        <= root_nxt;
      count_r       <= count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    k_r          <= k_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    need_r       <= need_nxt;
    steps_r      <= steps_nxt;
    len_r        <= len_nxt;
    dir_r        <= dir_nxt;
    to_root_r    <= to_root_nxt;
    new_r        <= new_nxt;
    node_r       <= node_nxt;
    res_found_r  <= res_found_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_value_r  <= out_value_nxt;
    out_total_r  <= out_total_nxt;
    out_status_r <= out_status_nxt;
  end

`ifndef ASSERT_OFF
  a_free_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_top_r <= CW'(NODE_COUNT))
    else $error("free stack pointer beyond pool size");

  a_unused_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_unused_r <= CW'(NODE_COUNT))
    else $error("never-used counter beyond pool size");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(NODE_COUNT))
    else $error("entry count beyond pool size");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_free |=> out_valid_r && (state_r == ST_IDLE))
    else $error("finished command did not load the result register");
`endif

endmodule
